>>> design/mp1d_pkg.sv
`timescale 1ns / 1ps
package mp1d_pkg;

  // Sizing of the block
  localparam int MAX_WINDOW  = 32;
  localparam int MAX_WINDOWS = 64;
  localparam int MAX_ROWS    = 16;
  localparam int VALUE_BITS  = 16;

  // Field and register widths
  localparam int ROW_W   = 4;
  localparam int COL_W   = 11;
  localparam int WS_W    = 6;
  localparam int WC_W    = 7;
  localparam int CDATA_W = 7;
  localparam int CIDX_W  = 2;
  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOWS);
  localparam int RIDX_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W  = RIDX_W + WIN_W;
  localparam int DEPTH   = MAX_ROWS * MAX_WINDOWS;
  localparam int BOUND_W = COL_W + 1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WINDOW_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TRAIN_MODE   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_FIRST_LAYER  = 2'd3;

  // Reset values of the registers
  localparam logic [WS_W-1:0] WS_RESET = 6'd2;
  localparam logic [WC_W-1:0] WC_RESET = 7'd8;

  // Item codes
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;
  localparam logic KIND_MAX  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  // Effective configuration handed to the core
  typedef struct packed {
    logic [WS_W-1:0]    ws;
    logic [WC_W-1:0]    wc;
    logic               train;
    logic               first;
    logic [BOUND_W-1:0] bound;
  } cfg_t;

  // One result from the core
  typedef struct packed {
    logic                         emit;
    logic                         kind;
    logic signed [VALUE_BITS-1:0] value;
    logic [COL_W-1:0]             column;
    logic                         last;
  } res_t;

endpackage

>>> design/max_pool_1d_argmax.sv
`timescale 1ns / 1ps
// One-dimensional max pooling with argmax, forward and backward. Forward
// items (one sample each) are taken one per cycle unless the input stalls;
// the last sample of a window puts the window maximum and its column into
// the output register, and in train mode stores the in-window argmax for
// that row and window. A backward item is accepted, the argmax store read,
// then window_size gradient elements go out, one per cycle while the output
// is free, the input stalled all the while; with first_layer set it is
// taken and yields nothing. Writing window_size or window_count realigns
// the column counter with a shared subtractor, one window per cycle, no
// item being taken meanwhile. A full output register stalls the input.
module max_pool_1d_argmax (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [mp1d_pkg::ROW_W-1:0]            in_row,
  input  logic signed [mp1d_pkg::VALUE_BITS-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_kind,
  output logic signed [mp1d_pkg::VALUE_BITS-1:0] out_value_res,
  output logic [mp1d_pkg::COL_W-1:0]            out_column,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mp1d_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [mp1d_pkg::CDATA_W-1:0]          cfg_data
);
  import mp1d_pkg::*;

  logic [WS_W-1:0]    ws_r;
  logic [WC_W-1:0]    wc_r;
  logic               train_r;
  logic               first_r;
  logic [BOUND_W-1:0] bound_r;
  logic [WS_W-1:0]    ws_eff;
  logic [WC_W-1:0]    wc_eff;
  logic [2*WC_W-1:0]  bound_full;
  logic               cfg_we;
  logic               resync;
  logic               out_free;
  cfg_t               cfg;
  res_t               res;

  logic                         out_valid_r;
  logic                         out_kind_r;
  logic signed [VALUE_BITS-1:0] out_value_r;
  logic [COL_W-1:0]             out_column_r;
  logic                         out_last_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign resync    = cfg_we && (cfg_index == REG_WINDOW_SIZE ||
                                cfg_index == REG_WINDOW_COUNT);

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= WS_RESET;
      wc_r    <= WC_RESET;
      train_r <= 1'b1;
      first_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  ws_r    <= cfg_data[WS_W-1:0];
        REG_WINDOW_COUNT: wc_r    <= cfg_data[WC_W-1:0];
        REG_TRAIN_MODE:   train_r <= cfg_data[0];
        REG_FIRST_LAYER:  first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range window settings
  always_comb begin
    if (ws_r == '0) begin
      ws_eff = WS_W'(1);
    end else if (ws_r > WS_W'(MAX_WINDOW)) begin
      ws_eff = WS_W'(MAX_WINDOW);
    end else begin
      ws_eff = ws_r;
    end
    if (wc_r == '0) begin
      wc_eff = WC_W'(1);
    end else if (wc_r > WC_W'(MAX_WINDOWS)) begin
      wc_eff = WC_W'(MAX_WINDOWS);
    end else begin
      wc_eff = wc_r;
    end
  end

  // Row length in samples
  assign bound_full = {{(WC_W-WS_W){1'b0}}, ws_eff} * wc_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= BOUND_W'(WS_RESET * WC_RESET);
    end else begin
      bound_r <= bound_full[BOUND_W-1:0];
    end
  end

  assign cfg.ws    = ws_eff;
  assign cfg.wc    = wc_eff;
  assign cfg.train = train_r;
  assign cfg.first = first_r;
  assign cfg.bound = bound_r;

  assign out_free = !out_valid_r || !out_stall;

  mp1d_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .resync   (resync),
    .out_free (out_free),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_row   (in_row),
    .in_value (in_value),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_kind_r   <= res.kind;
      out_value_r  <= res.value;
      out_column_r <= res.column;
      out_last_r   <= res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_value_res = out_value_r;
  assign out_column    = out_column_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |-> out_free)
    else $error("result produced while output register held");

  a_fwd_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_MAX) |-> out_last_r)
    else $error("pooled maximum without last flag");

  a_bwd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_BWD && !first_r) |=> in_stall)
    else $error("input taken during backward run");

  a_resync_busy: assert property (@(posedge clk) disable iff (!rst_n)
    resync |=> in_stall)
    else $error("input taken during window realignment");
`endif

endmodule

>>> design/mp1d_ram.sv
`timescale 1ns / 1ps
module mp1d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/mp1d_core.sv
`timescale 1ns / 1ps
module mp1d_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mp1d_pkg::cfg_t                   cfg,
  input  logic                             resync,
  input  logic                             out_free,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [mp1d_pkg::ROW_W-1:0]       in_row,
  input  logic signed [mp1d_pkg::VALUE_BITS-1:0] in_value,
  output mp1d_pkg::res_t                   res
);
  import mp1d_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RS_WAIT = 3'd1;
  localparam logic [2:0] ST_RS_INIT = 3'd2;
  localparam logic [2:0] ST_RS_DIV  = 3'd3;
  localparam logic [2:0] ST_BWD_RD  = 3'd4;
  localparam logic [2:0] ST_BWD_EM  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic signed [VALUE_BITS-1:0] max_r, max_nxt;
  logic [POS_W-1:0]             argmax_r, argmax_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [WIN_W-1:0]             win_r, win_nxt;
  logic [WIN_W-1:0]             bwd_win_r, bwd_win_nxt;
  logic [COL_W-1:0]             rem_r, rem_nxt;
  logic signed [VALUE_BITS-1:0] grad_r, grad_nxt;
  logic [WIN_W-1:0]             bwin_r, bwin_nxt;
  logic [POS_W-1:0]             idx_r, idx_nxt;
  logic [POS_W-1:0]             j_r, j_nxt;
  logic [COL_W-1:0]             bcol_r, bcol_nxt;

  // Shared adder: a + b + cin, carry out on top
  logic [COL_W-1:0]   alu_a, alu_b;
  logic               alu_cin;
  logic [BOUND_W-1:0] alu_sum;

  logic                 accept;
  logic [WS_W-1:0]      ws_m1;
  logic                 fwd_last;
  logic                 fwd_take;
  logic                 fwd_wrap;
  logic [WIN_W-1:0]     bwin_sel;
  logic [WC_W-1:0]      bwin_inc;
  logic [2*WS_W-1:0]    base_full;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [POS_W-1:0]     ram_rdata;
  logic [RIDX_W-1:0]    row_idx;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{COL_W{1'b0}}, alu_cin};

  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign row_idx  = in_row[RIDX_W-1:0];
  assign ws_m1    = cfg.ws - 1'b1;
  assign fwd_last = ({1'b0, pos_r} == ws_m1);
  assign fwd_take = (pos_r == '0) || (in_value > max_r);
  assign fwd_wrap = (alu_sum >= cfg.bound);
  assign bwin_sel = ({1'b0, bwd_win_r} >= cfg.wc) ? '0 : bwd_win_r;
  assign bwin_inc = {1'b0, bwin_sel} + 1'b1;
  assign base_full = {{WS_W{1'b0}}, bwin_r} * {{WIN_W{1'b0}}, cfg.ws};

  mp1d_ram #(
    .WIDTH (POS_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (argmax_nxt),
    .rdata (ram_rdata)
  );

  // Sequencer and datapath
  always_comb begin
    state_nxt   = state_r;
    max_nxt     = max_r;
    argmax_nxt  = argmax_r;
    col_nxt     = col_r;
    pos_nxt     = pos_r;
    win_nxt     = win_r;
    bwd_win_nxt = bwd_win_r;
    rem_nxt     = rem_r;
    grad_nxt    = grad_r;
    bwin_nxt    = bwin_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    bcol_nxt    = bcol_r;
    alu_a       = col_r;
    alu_b       = '0;
    alu_cin     = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = {row_idx, win_r};
    res         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_FWD) begin
          // running max, earliest sample wins ties
          if (fwd_take) begin
            max_nxt    = in_value;
            argmax_nxt = pos_r;
          end
          if (fwd_wrap) begin
            col_nxt = '0;
            pos_nxt = '0;
            win_nxt = '0;
          end else begin
            col_nxt = alu_sum[COL_W-1:0];
            if (fwd_last) begin
              pos_nxt = '0;
              win_nxt = win_r + 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          if (fwd_last) begin
            ram_we     = cfg.train;
            res.emit   = 1'b1;
            res.kind   = KIND_MAX;
            res.value  = max_nxt;
            res.column = col_r - {{(COL_W-POS_W){1'b0}}, pos_r}
                         + {{(COL_W-POS_W){1'b0}}, argmax_nxt};
            res.last   = 1'b1;
          end
        end else if (accept && !cfg.first) begin
          ram_addr    = {row_idx, bwin_sel};
          grad_nxt    = in_value;
          bwin_nxt    = bwin_sel;
          bwd_win_nxt = (bwin_inc >= cfg.wc) ? '0 : bwin_inc[WIN_W-1:0];
          state_nxt   = ST_BWD_RD;
        end
      end
      ST_BWD_RD: begin
        idx_nxt   = ram_rdata;
        j_nxt     = '0;
        bcol_nxt  = base_full[COL_W-1:0];
        state_nxt = ST_BWD_EM;
      end
      ST_BWD_EM: begin
        alu_a = bcol_r;
        if (out_free) begin
          res.emit   = 1'b1;
          res.kind   = KIND_GRAD;
          res.value  = (j_r == idx_r) ? grad_r : '0;
          res.column = bcol_r;
          res.last   = ({1'b0, j_r} == ws_m1);
          j_nxt      = j_r + 1'b1;
          bcol_nxt   = alu_sum[COL_W-1:0];
          if (res.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RS_WAIT: begin
        // bound register catches up with the new window settings
        state_nxt = ST_RS_INIT;
      end
      ST_RS_INIT: begin
        win_nxt = '0;
        if ({1'b0, col_r} >= cfg.bound) begin
          col_nxt = '0;
          rem_nxt = '0;
        end else begin
          rem_nxt = col_r;
        end
        state_nxt = ST_RS_DIV;
      end
      ST_RS_DIV: begin
        // realign window position: repeated subtract of window size
        alu_a   = rem_r;
        alu_b   = ~{{(COL_W-WS_W){1'b0}}, cfg.ws};
        alu_cin = 1'b1;
        if (alu_sum[COL_W]) begin
          rem_nxt = alu_sum[COL_W-1:0];
          win_nxt = win_r + 1'b1;
        end else begin
          pos_nxt   = rem_r[POS_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (resync) begin
      state_nxt = ST_RS_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      max_r     <= '0;
      argmax_r  <= '0;
      col_r     <= '0;
      pos_r     <= '0;
      win_r     <= '0;
      bwd_win_r <= '0;
    end else begin
      state_r   <= state_nxt;
      max_r     <= max_nxt;
      argmax_r  <= argmax_nxt;
      col_r     <= col_nxt;
      pos_r     <= pos_nxt;
      win_r     <= win_nxt;
      bwd_win_r <= bwd_win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    grad_r <= grad_nxt;
    bwin_r <= bwin_nxt;
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    bcol_r <= bcol_nxt;
  end

endmodule

>>> tb/max_pool_checker.sv
`timescale 1ns / 1ps
module max_pool_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic [mp1d_pkg::ROW_W-1:0]             in_row,
  input  logic signed [mp1d_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic                                   out_kind,
  input  logic signed [mp1d_pkg::VALUE_BITS-1:0] out_value_res,
  input  logic [mp1d_pkg::COL_W-1:0]             out_column,
  input  logic                                   out_last,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [mp1d_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [mp1d_pkg::CDATA_W-1:0]           cfg_data,
  output int                                     fail_count,
  output int                                     results_pending
);
  import mp1d_pkg::*;

  typedef struct packed {
    logic                         kind;
    logic signed [VALUE_BITS-1:0] value;
    logic [COL_W-1:0]             column;
    logic                         last;
  } pool_out_t;

  // Results still owed by the block, oldest first
  pool_out_t awaited_results[$];
  pool_out_t due;

  // Register copies, raw as written
  logic [WS_W-1:0] ws_reg;
  logic [WC_W-1:0] wc_reg;
  logic            train_reg;
  logic            first_reg;

  // Pooling state
  logic signed [VALUE_BITS-1:0] win_max;
  logic [POS_W-1:0]             win_arg;
  int unsigned                  fwd_col;
  int unsigned                  bwd_win;
  logic [POS_W-1:0]             argmax_mem [DEPTH];

  // Zero acts as one, oversize acts as the maximum
  function automatic int unsigned clamp_reg(int unsigned raw, int unsigned top_val);
    if (raw == 0) return 1;
    if (raw > top_val) return top_val;
    return raw;
  endfunction

  // Work out the results caused by one accepted item
  task automatic predict_pool(input logic mode, input logic [ROW_W-1:0] row,
                              input logic signed [VALUE_BITS-1:0] v);
    int unsigned ws;
    int unsigned wc;
    int unsigned pos;
    int unsigned win;
    int unsigned addr_base;
    logic [POS_W-1:0] idx;
    pool_out_t r;
    ws = clamp_reg(ws_reg, MAX_WINDOW);
    wc = clamp_reg(wc_reg, MAX_WINDOWS);
    addr_base = (int'(row) % MAX_ROWS) * MAX_WINDOWS;
    if (mode == MODE_FWD) begin
      if (fwd_col >= ws * wc) fwd_col = 0;
      pos = fwd_col % ws;
      win = fwd_col / ws;
      // first sample opens the window; ties keep the earlier one
      if (pos == 0 || v > win_max) begin
        win_max = v;
        win_arg = POS_W'(pos);
      end
      fwd_col++;
      if (fwd_col >= ws * wc) fwd_col = 0;
      if (pos == ws - 1) begin
        if (train_reg) argmax_mem[addr_base + win] = win_arg;
        r = '{kind: KIND_MAX, value: win_max, column: COL_W'(win * ws + win_arg),
              last: 1'b1};
        awaited_results.push_back(r);
      end
    end else if (!first_reg) begin
      if (bwd_win >= wc) bwd_win = 0;
      idx = argmax_mem[addr_base + bwd_win];
      // gradient lands on the stored argmax, zeros elsewhere
      for (int unsigned j = 0; j < ws; j++) begin
        r = '{kind: KIND_GRAD, value: (j == idx) ? v : '0,
              column: COL_W'(bwd_win * ws + j), last: (j == ws - 1)};
        awaited_results.push_back(r);
      end
      bwd_win++;
      if (bwd_win >= wc) bwd_win = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ws_reg = WS_RESET;
      wc_reg = WC_RESET;
      train_reg = 1'b1;
      first_reg = 1'b0;
      win_max = '0;
      win_arg = '0;
      fwd_col = 0;
      bwd_win = 0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with none expected: kind %0d value %0d column %0d",
                 out_kind, out_value_res, out_column);
          fail_count++;
        end else begin
          due = awaited_results.pop_front();
          if (due.kind !== out_kind) begin
            $error("kind: expected %0d, got %0d", due.kind, out_kind);
            fail_count++;
          end
          if (due.value !== out_value_res) begin
            $error("value_res: expected %0d, got %0d", due.value, out_value_res);
            fail_count++;
          end
          if (due.column !== out_column) begin
            $error("column: expected %0d, got %0d", due.column, out_column);
            fail_count++;
          end
          if (due.last !== out_last) begin
            $error("last: expected %0d, got %0d", due.last, out_last);
            fail_count++;
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_SIZE:  ws_reg = cfg_data[WS_W-1:0];
          REG_WINDOW_COUNT: wc_reg = cfg_data[WC_W-1:0];
          REG_TRAIN_MODE:   train_reg = cfg_data[0];
          REG_FIRST_LAYER:  first_reg = cfg_data[0];
          default: ;
        endcase
      end
      // input side
      if (in_valid && !in_stall) predict_pool(in_mode, in_row, in_value);
    end
    results_pending = awaited_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import mp1d_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_PHASES      = 9;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_mode = MODE_FWD;
  logic [ROW_W-1:0]             in_row = '0;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_kind;
  logic signed [VALUE_BITS-1:0] out_value_res;
  logic [COL_W-1:0]             out_column;
  logic                         out_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CIDX_W-1:0]            cfg_index = REG_WINDOW_SIZE;
  logic [CDATA_W-1:0]           cfg_data = '0;
  int                           fail_count;
  int                           results_pending;
  int                           cycles;

  // no random idling on either side while set
  bit steady = 1'b0;

  // Sender's view of the block, to keep backward items on stored windows
  int unsigned ws_eff = WS_RESET;
  int unsigned wc_eff = WC_RESET;
  bit          train_on = 1'b1;
  bit          first_on = 1'b0;
  int unsigned fcol = 0;
  int unsigned bwin = 0;
  bit          stored [MAX_ROWS][MAX_WINDOWS];
  int          cur_row = 0;

  // Directed row data: ties at both extremes, later maximum, two rows
  int dir_fwd_row [16] = '{0, 0, 0, 0, 0, 0, 0, 0,
                           15, 15, 15, 15, 15, 15, 15, 15};
  int dir_fwd_val [16] = '{-32768, -32768, 32767, 32767, 0, 1, -1, -2,
                           256, -256, -5, 7, 100, 100, -32768, 32767};
  int dir_bwd_row [8]  = '{0, 0, 0, 0, 15, 15, 15, 15};
  int dir_bwd_val [8]  = '{32767, -32768, 1, -1, 0, 256, -256, 21845};

  // Register settings per phase, raw values
  int ph_ws     [N_PHASES] = '{2, 1, 32, 0, 5, 3, 4, 1, 63};
  int ph_wc     [N_PHASES] = '{8, 1, 1, 0, 3, 3, 127, 127, 1};
  int ph_train  [N_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1};
  int ph_first  [N_PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0, 0};
  int ph_items  [N_PHASES] = '{8, 8, 34, 6, 10, 8, 8, 6, 8};
  int ph_steady [N_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0};

  max_pool_1d_argmax i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_row        (in_row),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_value_res (out_value_res),
    .out_column    (out_column),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  max_pool_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_value_res   (out_value_res),
    .out_column      (out_column),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 8);
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned clamp_reg(int unsigned raw, int unsigned top_val);
    if (raw == 0) return 1;
    if (raw > top_val) return top_val;
    return raw;
  endfunction

  // Present one item, hold it until taken, then track the sample counters
  task automatic send_item(input logic mode, input int row, input int val);
    logic taken;
    if (!steady) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_row   <= ROW_W'(row);
    in_value <= VALUE_BITS'(val);
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (mode == MODE_FWD) begin
      if (fcol >= ws_eff * wc_eff) fcol = 0;
      if ((fcol % ws_eff) == ws_eff - 1 && train_on) stored[row][fcol / ws_eff] = 1'b1;
      fcol++;
      if (fcol >= ws_eff * wc_eff) fcol = 0;
    end else if (!first_on) begin
      if (bwin >= wc_eff) bwin = 0;
      bwin++;
      if (bwin >= wc_eff) bwin = 0;
    end
  endtask

  // Sender holds off until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  // One register beat; valid stays high for the caller's next beat
  task automatic cfg_beat(input logic [CIDX_W-1:0] idx, input int data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CDATA_W'(data);
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_config(input int ws, input int wc, input int train, input int first);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_beat(REG_WINDOW_SIZE, ws);
    cfg_beat(REG_WINDOW_COUNT, wc);
    cfg_beat(REG_TRAIN_MODE, train);
    cfg_beat(REG_FIRST_LAYER, first);
    cfg_valid <= 1'b0;
    ws_eff   = clamp_reg(ws & 'h3f, MAX_WINDOW);
    wc_eff   = clamp_reg(wc & 'h7f, MAX_WINDOWS);
    train_on = train[0];
    first_on = first[0];
  endtask

  // One random item: mostly whole rows and backward runs on stored windows
  task automatic random_item();
    int rows_ok[$];
    int unsigned bw_now;
    int row;
    int val;
    bw_now = (bwin >= wc_eff) ? 0 : bwin;
    for (int r = 0; r < MAX_ROWS; r++) begin
      if (first_on || stored[r][bw_now]) rows_ok.push_back(r);
    end
    if (rows_ok.size() > 0 && $urandom_range(0, 99) < 35) begin
      row = rows_ok[$urandom_range(0, rows_ok.size() - 1)];
      send_item(MODE_BWD, row, int'($urandom));
    end else begin
      if (fcol >= ws_eff * wc_eff || fcol == 0) cur_row = $urandom_range(0, MAX_ROWS - 1);
      // a stray row now and then breaks the sequence
      row = ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, MAX_ROWS - 1)) : cur_row;
      // narrow values make ties likely
      val = ($urandom_range(0, 99) < 30) ? int'($urandom_range(0, 6)) - 3 : int'($urandom);
      send_item(MODE_FWD, row, val);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a full row at reset settings, then a backward run per window
    for (int i = 0; i < 16; i++) send_item(MODE_FWD, dir_fwd_row[i], dir_fwd_val[i]);
    for (int i = 0; i < 8; i++) send_item(MODE_BWD, dir_bwd_row[i], dir_bwd_val[i]);

    // random phases over the register settings
    for (int p = 0; p < N_PHASES; p++) begin
      write_config(ph_ws[p], ph_wc[p], ph_train[p], ph_first[p]);
      steady = ph_steady[p][0];
      for (int n = 0; n < ph_items[p]; n++) begin
        if (n == ph_items[p] / 2) wait_drained();
        random_item();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
